// ----- src/sssp_pkg.sv -----
// ----------------------------------------------------------------------------
// sssp_pkg: shared types and constants for the shortest path block
// Sizes, operation codes and the data carried along the chain of cells.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int NODES       = 16;
  localparam int NODE_BITS   = 4;
  localparam int WEIGHT_BITS = 16;
  localparam int COST_BITS   = 20;
  localparam int CNT_BITS    = 5;
  localparam int EDGE_BITS   = 2 * NODE_BITS;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                 clear;     // start of a run
    logic                 seed;      // mark source known at cost zero
    logic [NODE_BITS-1:0] src;
    logic                 relax;     // relaxation pass active
    logic [NODE_BITS-1:0] u;         // node being settled
    logic [COST_BITS-1:0] u_cost;
    logic                 edge_ok;   // current edge u->v valid
    logic [NODE_BITS-1:0] v;         // node under relaxation
    logic [WEIGHT_BITS-1:0] w;
    logic                 settle;    // mark u settled
  } cell_ctl_t;

  // candidate passed along the chain during selection
  typedef struct packed {
    logic                 found;
    logic [NODE_BITS-1:0] node;
    logic [COST_BITS-1:0] cost;
  } cand_t;

endpackage

// ----- src/sssp_cell.sv -----
// ----------------------------------------------------------------------------
// sssp_cell: one node of the graph
// Holds cost, parent and flags for one node, relaxes its own entry and
// merges itself into the running minimum handed on from its left neighbor.
// ----------------------------------------------------------------------------
module sssp_cell
  import sssp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [NODE_BITS-1:0] my_id,
  input  logic                 active,
  input  cell_ctl_t            ctl,
  input  cand_t                cand_in,
  output cand_t                cand_out,
  output logic                 known,
  output logic [COST_BITS-1:0] cost,
  output logic [NODE_BITS-1:0] parent
);

  logic settled;
  logic [COST_BITS-1:0] cand_cost;
  logic hit;
  cand_t merged;

  assign cand_cost = ctl.u_cost + COST_BITS'(ctl.w);
  assign hit = ctl.relax && ctl.edge_ok && (ctl.v == my_id) && active
               && (!known || cost > cand_cost);

  // node state
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      known   <= 1'b0;
      settled <= 1'b0;
    end else begin
      if (ctl.seed && ctl.src == my_id && active) begin
        known <= 1'b1;
        cost  <= '0;
      end else if (hit) begin
        known  <= 1'b1;
        cost   <= cand_cost;
        parent <= ctl.u;
      end
      if (ctl.settle && ctl.u == my_id) settled <= 1'b1;
    end
  end

  // merge into running minimum; strict less keeps the lower index on ties
  always_comb begin
    merged = cand_in;
    if (known && !settled && active && (!cand_in.found || cost < cand_in.cost)) begin
      merged.found = 1'b1;
      merged.node  = my_id;
      merged.cost  = cost;
    end
  end

  // hand the candidate to the right neighbor
  always_ff @(posedge clk) begin
    if (rst) cand_out <= '0;
    else cand_out <= merged;
  end

endmodule

// ----- src/sssp_chain.sv -----
// ----------------------------------------------------------------------------
// sssp_chain: row of node cells
// Cells hand the selection candidate from low to high index, one cell per
// cycle, so a selection settles once it has passed every cell register.
// ----------------------------------------------------------------------------
module sssp_chain
  import sssp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CNT_BITS-1:0]  n_act,
  input  cell_ctl_t            ctl,
  output cand_t                best,
  input  logic [NODE_BITS-1:0] rd_node,
  output logic                 rd_known,
  output logic [COST_BITS-1:0] rd_cost,
  output logic [NODE_BITS-1:0] rd_parent
);

  cand_t                link   [NODES+1];
  logic                 kn     [NODES];
  logic [COST_BITS-1:0] cs     [NODES];
  logic [NODE_BITS-1:0] pr     [NODES];

  assign link[0] = '0;

  for (genvar i = 0; i < NODES; i++) begin : g_cell
    sssp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .my_id    (NODE_BITS'(i)),
      .active   (CNT_BITS'(i) < n_act),
      .ctl      (ctl),
      .cand_in  (link[i]),
      .cand_out (link[i+1]),
      .known    (kn[i]),
      .cost     (cs[i]),
      .parent   (pr[i])
    );
  end

  // chain tail, already registered in the last cell
  assign best = link[NODES];

  assign rd_known  = kn[rd_node];
  assign rd_cost   = cs[rd_node];
  assign rd_parent = pr[rd_node];

endmodule

// ----- src/single_source_shortest_path.sv -----
// ----------------------------------------------------------------------------
// single_source_shortest_path: Dijkstra over a dense 16-node graph
// Edge matrix in a memory, node state in a chain of cells.
// ----------------------------------------------------------------------------
// A load item writes one edge, so loads can follow back to back.
// A run item clears the cells, seeds the source and then settles nodes one
// at a time. Each selection first drains the last relaxation of a pass, if
// any, then lets the candidate cross all 16 cells and ends in the pick state;
// each settled node then reads its row from the edge memory, one entry a
// cycle on one read port. Results are sent one at a time while the receiver
// is ready, and the next result is formed only after the last one is taken.
// No item is accepted during a run.
module single_source_shortest_path
  import sssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tuser: operation[0]
  input  logic        s_tuser,
  // tdata: from_node[3:0], to_node[7:4], edge_weight[23:8], edge_exists[24],
  //        source_node[28:25], zero fill[31:29]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: node_index[3:0], path_cost[23:4], reachable[24], predecessor[28:25],
  //        has_predecessor[29], zero fill[31:30]
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEL  = 3'd1;
  localparam logic [2:0] ST_PICK = 3'd2;
  localparam logic [2:0] ST_REL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;
  localparam logic [2:0] ST_SEED = 3'd6;

  logic [2:0]           state;
  logic [4:0]           cfg_n;
  logic [CNT_BITS-1:0]  n_act;
  logic [NODE_BITS-1:0] src;
  logic [NODE_BITS-1:0] u;
  logic [COST_BITS-1:0] u_cost;
  logic [CNT_BITS-1:0]  idx;
  logic                 rel_vld;
  logic [NODE_BITS-1:0] rel_v;
  logic                 valid_bits [NODES*NODES];
  logic [WEIGHT_BITS-1:0] edge_mem [NODES*NODES];
  logic [WEIGHT_BITS-1:0] rd_w;
  logic                 rd_ok;
  cell_ctl_t            ctl;
  cand_t                best;
  logic                 rk;
  logic [COST_BITS-1:0] rc;
  logic [NODE_BITS-1:0] rp;
  logic                 accept;
  logic                 ld;
  logic [NODE_BITS-1:0] in_from, in_to, in_src;

  assign accept  = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign in_from = s_tdata[3:0];
  assign in_to   = s_tdata[7:4];
  assign in_src  = s_tdata[28:25];
  assign ld      = accept && s_tuser == OP_LOAD;

  // clamp of nodes_in_use
  assign n_act = (cfg_n == 5'd0) ? CNT_BITS'(1) :
                 (cfg_n > 5'(NODES)) ? CNT_BITS'(NODES) : CNT_BITS'(cfg_n);

  always_ff @(posedge clk) begin
    if (rst) cfg_n <= 5'(NODES);
    else if (cfg_we) cfg_n <= cfg_wdata;
  end

  // edge memory: valid bits in flops, weights in a RAM with registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES*NODES; i++) valid_bits[i] <= 1'b0;
    end else if (ld) begin
      valid_bits[{in_from, in_to}] <= s_tdata[24];
    end
  end

  always_ff @(posedge clk) begin
    if (ld && s_tdata[24]) edge_mem[{in_from, in_to}] <= s_tdata[23:8];
    rd_w  <= edge_mem[{u, idx[NODE_BITS-1:0]}];
    rd_ok <= valid_bits[{u, idx[NODE_BITS-1:0]}];
  end

  // broadcast control; on a pick the new node is settled right away
  always_comb begin
    ctl         = '0;
    ctl.clear   = accept && s_tuser == OP_RUN;
    ctl.seed    = (state == ST_SEED);
    ctl.src     = src;
    ctl.relax   = rel_vld;
    ctl.u       = (state == ST_PICK) ? best.node : u;
    ctl.u_cost  = u_cost;
    ctl.edge_ok = rd_ok;
    ctl.v       = rel_v;
    ctl.w       = rd_w;
    ctl.settle  = (state == ST_PICK) && best.found;
  end

  sssp_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .n_act     (n_act),
    .ctl       (ctl),
    .best      (best),
    .rd_node   (idx[NODE_BITS-1:0]),
    .rd_known  (rk),
    .rd_cost   (rc),
    .rd_parent (rp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rel_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && s_tuser == OP_RUN) begin
            src   <= in_src;
            idx   <= '0;
            state <= ST_SEED;
          end
        end
        ST_SEED: begin
          idx   <= '0;
          state <= ST_SEL;
        end
        ST_SEL: begin
          // last relax drains, then the candidate crosses every cell
          rel_vld <= 1'b0;
          if (rel_vld) begin
            idx <= '0;
          end else if (idx == CNT_BITS'(NODES - 1)) begin
            idx   <= '0;
            state <= ST_PICK;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_PICK: begin
          if (best.found) begin
            u      <= best.node;
            u_cost <= best.cost;
            idx    <= '0;
            state  <= ST_REL;
          end else begin
            idx   <= '0;
            state <= ST_OUT;
          end
        end
        ST_REL: begin
          rel_vld <= 1'b1;
          rel_v   <= idx[NODE_BITS-1:0];
          if (idx == n_act - 1'b1) begin
            state <= ST_SEL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_OUT: begin
          m_tvalid <= 1'b1;
          m_tlast  <= (idx == n_act - 1'b1);
          m_tdata  <= {2'b00, rk && (idx[NODE_BITS-1:0] != src),
                       (rk && idx[NODE_BITS-1:0] != src) ? rp : '0,
                       rk, rk ? rc : '0, idx[NODE_BITS-1:0]};
          state    <= ST_WAIT;
        end
        ST_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_OUT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready) else $error("input taken while busy");
  a_out_only_wait: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == ST_WAIT) else $error("result outside wait");
  a_out_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> CNT_BITS'(m_tdata[3:0]) < n_act) else $error("bad node index");

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for single_source_shortest_path
// Loads random sparse and dense graphs, runs Dijkstra from random sources
// under several node counts and checks every node result against an
// in-bench predictor, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
import sssp_pkg::*;

typedef struct packed {
  logic [NODE_BITS-1:0] node;
  logic [COST_BITS-1:0] cost;
  logic                 reach;
  logic [NODE_BITS-1:0] pred;
  logic                 has_pred;
  logic                 last;
} node_result_t;

class path_scoreboard;
  logic                   edge_on [NODES*NODES];
  logic [WEIGHT_BITS-1:0] edge_w  [NODES*NODES];
  logic [4:0]             node_count;
  node_result_t           pending_results[$];
  int                     errors;

  function void init();
    foreach (edge_on[i]) begin
      edge_on[i] = 1'b0;
      edge_w[i] = '0;
    end
    node_count = 5'd16;
    errors = 0;
  endfunction

  // note one accepted input item; a run item queues its node results
  function void note_item(logic op, logic [31:0] d);
    logic [NODE_BITS-1:0]   fr, to, src;
    int                     n, u, best, idx;
    logic [COST_BITS-1:0]   cost_of [NODES];
    logic [COST_BITS-1:0]   cand;
    logic                   known [NODES];
    logic                   done [NODES];
    logic [NODE_BITS-1:0]   par [NODES];
    node_result_t           r;
    fr = d[3:0];
    to = d[7:4];
    src = d[28:25];
    if (op == OP_LOAD) begin
      idx = fr * NODES + to;
      edge_on[idx] = d[24];
      if (d[24]) edge_w[idx] = d[23:8];
      return;
    end
    n = node_count;
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    for (int i = 0; i < NODES; i++) begin
      cost_of[i] = '0;
      known[i] = 1'b0;
      done[i] = 1'b0;
      par[i] = '0;
    end
    if (src < n) known[src] = 1'b1;
    forever begin
      // least-cost unsettled known node, lowest index on ties
      best = -1;
      for (int i = 0; i < n; i++)
        if (known[i] && !done[i] && (best < 0 || cost_of[i] < cost_of[best])) best = i;
      if (best < 0) break;
      u = best;
      for (int v = 0; v < n; v++) begin
        idx = u * NODES + v;
        if (edge_on[idx]) begin
          cand = cost_of[u] + edge_w[idx];
          if (!known[v] || cost_of[v] > cand) begin
            known[v] = 1'b1;
            cost_of[v] = cand;
            par[v] = u[NODE_BITS-1:0];
          end
        end
      end
      done[u] = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      r.node = i[NODE_BITS-1:0];
      r.reach = known[i];
      r.cost = known[i] ? cost_of[i] : '0;
      r.has_pred = known[i] && (i != src);
      r.pred = r.has_pred ? par[i] : '0;
      r.last = (i == n - 1);
      pending_results.push_back(r);
    end
  endfunction

  function void check_result(logic [31:0] d, logic tl);
    node_result_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result item %h", d);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (d[3:0] !== e.node) begin
      $error("node_index exp %0d got %0d", e.node, d[3:0]); errors++;
    end
    if (d[23:4] !== e.cost) begin
      $error("path_cost exp %0d got %0d", e.cost, d[23:4]); errors++;
    end
    if (d[24] !== e.reach) begin
      $error("reachable exp %0d got %0d", e.reach, d[24]); errors++;
    end
    if (d[28:25] !== e.pred) begin
      $error("predecessor exp %0d got %0d", e.pred, d[28:25]); errors++;
    end
    if (d[29] !== e.has_pred) begin
      $error("has_predecessor exp %0d got %0d", e.has_pred, d[29]); errors++;
    end
    if (tl !== e.last) begin
      $error("last_result exp %0d got %0d", e.last, tl); errors++;
    end
  endfunction
endclass

module testbench;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic        s_tuser = 1'b0;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  path_scoreboard sb;
  int idle_cycles;
  int rx_gap;

  single_source_shortest_path dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one item after a random gap, then hold it until accepted
  task automatic send_item(logic op, logic [31:0] d);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] edge_item(int fr, int to, int w, bit on);
    return {3'd0, 4'($urandom), on, 16'(w), 4'(to), 4'(fr)};
  endfunction

  function automatic logic [31:0] run_item(int src);
    logic [31:0] d;
    d = {3'd0, 4'(src), 1'($urandom), 16'($urandom), 4'($urandom), 4'($urandom)};
    return d;
  endfunction

  task automatic set_nodes(logic [4:0] v);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.node_count = v;
  endtask

  // random graph over the first n nodes plus stray loads anywhere, then a few runs
  task automatic random_phase(int n, int loads, int runs);
    int w;
    for (int k = 0; k < loads; k++) begin
      case ($urandom_range(0, 3))
        0: w = 0;
        1: w = 65535;
        default: w = $urandom_range(0, 300);
      endcase
      if ($urandom_range(0, 9) == 0)
        send_item(OP_LOAD, {$urandom} & 32'h1FFF_FFFF);
      else
        send_item(OP_LOAD, edge_item($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                     w, $urandom_range(0, 3) != 0));
    end
    for (int k = 0; k < runs; k++)
      send_item(OP_RUN, run_item($urandom_range(0, 9) == 0 ? $urandom_range(0, 15)
                                                           : $urandom_range(0, n - 1)));
  endtask

  // receiver: one ready cycle, then a random stall, possibly none
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap <= 0;
    end else if (rx_gap > 0) begin
      m_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      m_tready <= 1'b1;
      rx_gap <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  // watchdog: cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
  end

  initial begin
    sb = new();
    sb.init();
    idle_cycles = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: small chain with ties, zero and max weights, removals
    send_item(OP_LOAD, edge_item(0, 1, 5, 1));
    send_item(OP_LOAD, edge_item(0, 2, 5, 1));
    send_item(OP_LOAD, edge_item(1, 3, 0, 1));
    send_item(OP_LOAD, edge_item(2, 3, 0, 1));
    send_item(OP_LOAD, edge_item(3, 3, 1, 1));
    send_item(OP_LOAD, edge_item(3, 0, 0, 1));
    send_item(OP_LOAD, edge_item(15, 15, 65535, 1));
    send_item(OP_LOAD, edge_item(14, 15, 65535, 1));
    send_item(OP_LOAD, edge_item(3, 14, 65535, 1));
    send_item(OP_LOAD, edge_item(1, 3, 9, 0));
    send_item(OP_RUN, run_item(0));
    send_item(OP_RUN, run_item(15));
    send_item(OP_LOAD, edge_item(2, 3, 7, 0));
    send_item(OP_RUN, run_item(0));
    set_nodes(5'd4);
    send_item(OP_RUN, run_item(0));
    send_item(OP_RUN, run_item(9));
    set_nodes(5'd0);
    send_item(OP_RUN, run_item(0));
    send_item(OP_RUN, run_item(1));
    set_nodes(5'd31);
    send_item(OP_RUN, run_item(3));
    set_nodes(5'd17);
    send_item(OP_RUN, run_item(14));

    // random phases across node counts
    for (int ph = 0; ph < 10; ph++) begin
      set_nodes(ph % 3 == 0 ? 5'd16 : 5'($urandom_range(1, 16)));
      random_phase(sb.node_count == 0 ? 1 :
                   (sb.node_count > 16 ? 16 : int'(sb.node_count)), 28, 3);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
